// File: sv/ftfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftfm_pkg
// Shared types and constants of the five-tuple first-match filter.
// ----------------------------------------------------------------------------
package ftfm_pkg;

    localparam int RULE_SLOTS_DEF = 16;

    localparam logic [1:0] REQ_APPEND   = 2'd0;
    localparam logic [1:0] REQ_CLEAR    = 2'd1;
    localparam logic [1:0] REQ_CLASSIFY = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] src_addr;
        logic        src_addr_any;
        logic [31:0] dst_addr;
        logic        dst_addr_any;
        logic [15:0] src_port_num;
        logic [15:0] dst_port_num;
        logic [7:0]  proto_num;
        logic        rule_allows;
    } req_t;

    typedef struct packed {
        logic       allow;
        logic       hit;
        logic [3:0] hit_index;
        logic       status;
    } rsp_t;

    // one stored rule, kept as a single memory word
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port_num;
        logic [15:0] dst_port_num;
        logic [7:0]  proto_num;
        logic        src_addr_any;
        logic        dst_addr_any;
        logic        rule_allows;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// File: sv/ftfm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftfm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ftfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/five_tuple_first_match_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_tuple_first_match_filter
// Ordered packet filter rule table with a first-match classifier.
//
// s_data carries one request: append a rule, clear the table, or classify a
// packet header. Every request gives exactly one response on m_data.
// Rules live in one synchronous RAM word per slot; a classify request reads
// them in table order, one rule per cycle, and stops at the first match.
// Append, clear, a reserved code and a classify on an empty table go from
// acceptance straight to the finish state; a classify scan ends at the
// first hit or after the last stored rule. The single RAM read port sets
// the scan rate.
// One request is in work at a time; s_ready rises again as soon as the
// response is in the output register, so the next request is taken while
// that response still waits on a stalled m_ready. A response that finds
// the output register still full holds until it is taken.
// Reset (aresetn low, synchronous) empties the table and drops m_valid; no
// clearing pass is needed, slots at or above the rule count are never used.
// ----------------------------------------------------------------------------
module five_tuple_first_match_filter
    import ftfm_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  scan_idx_reg;
    req_t              req_reg;
    rsp_t              res_reg;
    logic              m_valid_reg;
    rsp_t              m_data_reg;

    logic              s_fire;
    logic              out_free;
    logic              table_full;
    logic              table_empty;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [RULE_W-1:0] ram_rdata;
    rule_t             rule;
    rule_t             new_rule;
    logic              rule_hit;
    logic [CNT_W:0]    scan_next_ext;
    logic              scan_last;
    logic [IDX_W+3:0]  scan_idx_ext;
    rsp_t              accept_res;

    assign s_fire      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign table_full  = (count_reg == CNT_W'(RULE_SLOTS));
    assign table_empty = (count_reg == '0);

    assign new_rule.src_addr     = s_data.src_addr;
    assign new_rule.dst_addr     = s_data.dst_addr;
    assign new_rule.src_port_num = s_data.src_port_num;
    assign new_rule.dst_port_num = s_data.dst_port_num;
    assign new_rule.proto_num    = s_data.proto_num;
    assign new_rule.src_addr_any = s_data.src_addr_any;
    assign new_rule.dst_addr_any = s_data.dst_addr_any;
    assign new_rule.rule_allows  = s_data.rule_allows;

    // writes only happen in idle and reads are consumed only in scan, so the
    // state machine keeps the two ports from touching the same slot at once
    ftfm_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (new_rule),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rule = rule_t'(ram_rdata);

    assign rule_hit =
        (rule.src_addr_any || (rule.src_addr == req_reg.src_addr)) &&
        (rule.dst_addr_any || (rule.dst_addr == req_reg.dst_addr)) &&
        ((rule.src_port_num == '0) || (rule.src_port_num == req_reg.src_port_num)) &&
        ((rule.dst_port_num == '0) || (rule.dst_port_num == req_reg.dst_port_num)) &&
        ((rule.proto_num == '0) || (rule.proto_num == req_reg.proto_num));

    assign scan_next_ext = {{(CNT_W + 1 - IDX_W){1'b0}}, scan_idx_reg} + 1'b1;
    assign scan_last     = (scan_next_ext == {1'b0, count_reg});
    assign scan_idx_ext  = {4'b0000, scan_idx_reg};

    // response for requests that finish without a scan, and the miss result of a scan
    always_comb begin
        accept_res = '0;
        case (s_data.req_type)
            REQ_APPEND: begin
                accept_res.status = table_full ? STATUS_FULL : STATUS_OK;
            end
            REQ_CLASSIFY: begin
                accept_res.allow = 1'b1;
            end
            default: begin
                accept_res = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.req_type == REQ_CLASSIFY && !table_empty) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (rule_hit || scan_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                ram_we  = s_valid && (s_data.req_type == REQ_APPEND) && !table_full;
            end
            ST_SCAN: begin
                ram_raddr = scan_next_ext[IDX_W-1:0];
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                if (s_data.req_type == REQ_APPEND && !table_full) begin
                    count_reg <= count_reg + 1'b1;
                end else if (s_data.req_type == REQ_CLEAR) begin
                    count_reg <= '0;
                end
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg      <= s_data;
            res_reg      <= accept_res;
            scan_idx_reg <= '0;
        end
        if (state_reg == ST_SCAN) begin
            if (rule_hit) begin
                res_reg.allow     <= rule.rule_allows;
                res_reg.hit       <= 1'b1;
                res_reg.hit_index <= scan_idx_ext[3:0];
            end else if (!scan_last) begin
                scan_idx_reg <= scan_next_ext[IDX_W-1:0];
            end
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/ftfm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftfm_checker
// Port-level checks of the five-tuple first-match filter, bound to the top.
// ----------------------------------------------------------------------------
module ftfm_checker
    import ftfm_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input req_t s_data,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // reset drops any pending response
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_resp_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled response changed");

    // one request in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in work");

    // full status only comes from an append, which never hits or allows
    a_full_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status |-> !m_data.allow && !m_data.hit)
        else $error("full status mixed with classify result");

    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.hit_index == '0)
        else $error("nonzero index without a hit");

endmodule

bind five_tuple_first_match_filter ftfm_checker u_ftfm_checker (.*);

// File: tb/five_tuple_first_match_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_tuple_first_match_filter_test
// Self-checking bench for the first-match packet filter. Requests go in on
// the s_ side; a local copy of the rule table predicts every response, and
// each response on the m_ side is checked against the oldest prediction.
// Directed cases cover the empty table, field extremes, a full table and
// clearing. Random traffic then builds rule sets and classifies packets
// aimed at them, under several idle patterns and one long output stall.
// ----------------------------------------------------------------------------
module five_tuple_first_match_filter_test;
    import ftfm_pkg::*;

    localparam logic [1:0] REQ_RESERVED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // local copy of the rule table
    rule_t       rule_table [RULE_SLOTS_DEF];
    int unsigned rules_held = 0;

    rsp_t awaited_verdicts [$];
    rsp_t verdict_due;
    int   mismatches = 0;
    int   requests_sent = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;

    five_tuple_first_match_filter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic rule_hits(input rule_t rl, input req_t p);
        return (rl.src_addr_any || rl.src_addr == p.src_addr)
            && (rl.dst_addr_any || rl.dst_addr == p.dst_addr)
            && (rl.src_port_num == 16'd0 || rl.src_port_num == p.src_port_num)
            && (rl.dst_port_num == 16'd0 || rl.dst_port_num == p.dst_port_num)
            && (rl.proto_num == 8'd0 || rl.proto_num == p.proto_num);
    endfunction

    // updates the local table and returns the response the request earns
    function automatic rsp_t apply_filter_request(input req_t r);
        rsp_t v;
        v = '0;
        case (r.req_type)
            REQ_APPEND: begin
                if (rules_held >= RULE_SLOTS_DEF) begin
                    v.status = STATUS_FULL;
                end else begin
                    rule_table[rules_held].src_addr     = r.src_addr;
                    rule_table[rules_held].dst_addr     = r.dst_addr;
                    rule_table[rules_held].src_port_num = r.src_port_num;
                    rule_table[rules_held].dst_port_num = r.dst_port_num;
                    rule_table[rules_held].proto_num    = r.proto_num;
                    rule_table[rules_held].src_addr_any = r.src_addr_any;
                    rule_table[rules_held].dst_addr_any = r.dst_addr_any;
                    rule_table[rules_held].rule_allows  = r.rule_allows;
                    rules_held++;
                end
            end
            REQ_CLEAR: begin
                rules_held = 0;
            end
            REQ_CLASSIFY: begin
                v.allow = 1'b1;
                for (int i = 0; i < rules_held; i++) begin
                    if (!v.hit && rule_hits(rule_table[i], r)) begin
                        v.hit = 1'b1;
                        v.allow = rule_table[i].rule_allows;
                        v.hit_index = i[3:0];
                    end
                end
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic req_t make_request(input logic [1:0] kind,
                                          input logic [31:0] sa, input logic sany,
                                          input logic [31:0] da, input logic dany,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [7:0] pr, input logic act);
        req_t r;
        r.req_type     = kind;
        r.src_addr     = sa;
        r.src_addr_any = sany;
        r.dst_addr     = da;
        r.dst_addr_any = dany;
        r.src_port_num = sp;
        r.dst_port_num = dp;
        r.proto_num    = pr;
        r.rule_allows  = act;
        return r;
    endfunction

    // small value pools make rules overlap so first-match order matters
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hC0A8_0001;
            3: return 32'h0A00_0001;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd80;
            3: return 16'd443;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd6;
            2: return 8'd17;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic req_t random_rule();
        return make_request(REQ_APPEND, pick_addr(), $urandom_range(0, 3) == 0,
                            pick_addr(), $urandom_range(0, 3) == 0, pick_port(),
                            pick_port(), pick_proto(), 1'($urandom_range(0, 1)));
    endfunction

    function automatic req_t random_packet();
        req_t  p;
        rule_t rl;
        p = make_request(REQ_CLASSIFY, pick_addr(), 1'($urandom_range(0, 1)), pick_addr(),
                         1'($urandom_range(0, 1)), pick_port(), pick_port(), pick_proto(),
                         1'($urandom_range(0, 1)));
        // mostly aim at a stored rule, sometimes just off by one field
        if (rules_held != 0 && $urandom_range(0, 99) < 65) begin
            rl = rule_table[$urandom_range(0, rules_held - 1)];
            if (!rl.src_addr_any) p.src_addr = rl.src_addr;
            if (!rl.dst_addr_any) p.dst_addr = rl.dst_addr;
            if (rl.src_port_num != 16'd0) p.src_port_num = rl.src_port_num;
            if (rl.dst_port_num != 16'd0) p.dst_port_num = rl.dst_port_num;
            if (rl.proto_num != 8'd0) p.proto_num = rl.proto_num;
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0: p.src_addr = p.src_addr ^ (32'h1 << $urandom_range(0, 31));
                    1: p.dst_addr = p.dst_addr ^ (32'h1 << $urandom_range(0, 31));
                    2: p.src_port_num = p.src_port_num ^ (16'h1 << $urandom_range(0, 15));
                    3: p.dst_port_num = p.dst_port_num ^ (16'h1 << $urandom_range(0, 15));
                    default: p.proto_num = p.proto_num ^ (8'h1 << $urandom_range(0, 7));
                endcase
            end
        end
        return p;
    endfunction

    // called at a rising edge; returns at the edge that takes the request
    task automatic send_request(input req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        awaited_verdicts.push_back(apply_filter_request(r));
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (awaited_verdicts.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: allow=%0b hit=%0b index=%0d status=%0b",
                             m_data.allow, m_data.hit, m_data.hit_index, m_data.status);
            end else begin
                verdict_due = awaited_verdicts.pop_front();
                if (m_data.allow !== verdict_due.allow || m_data.hit !== verdict_due.hit ||
                    m_data.hit_index !== verdict_due.hit_index ||
                    m_data.status !== verdict_due.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "mismatch at %0t: expected allow=%0b hit=%0b index=%0d status=%0b",
                            $realtime, verdict_due.allow, verdict_due.hit,
                            verdict_due.hit_index, verdict_due.status,
                            ", got allow=%0b hit=%0b index=%0d status=%0b",
                            m_data.allow, m_data.hit, m_data.hit_index, m_data.status);
                end
            end
        end
    end

    // empty table, extreme field values, unused request code
    task automatic test_basic_rules();
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        send_request(make_request(REQ_CLASSIFY, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                                  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
        send_request(make_request(REQ_APPEND, 32'h0, 1'b0, 32'h0, 1'b0,
                                  16'd0, 16'd0, 8'd0, 1'b0));
        send_request(make_request(REQ_APPEND, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                                  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
        send_request(make_request(REQ_CLASSIFY, 32'h0, 1'b1, 32'h0, 1'b1,
                                  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
        send_request(make_request(REQ_CLASSIFY, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0,
                                  16'hFFFF, 16'hFFFF, 8'hFF, 1'b0));
        send_request(make_request(REQ_CLASSIFY, 32'h1, 1'b0, 32'h1, 1'b0,
                                  16'd1, 16'd1, 8'd1, 1'b0));
        send_request(make_request(REQ_RESERVED, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
                                  16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
        wait_drained();
    endtask

    // fill the table, overflow it, hit the last slot, then clear
    task automatic test_table_full();
        req_t last_pkt;
        for (int i = 2; i < RULE_SLOTS_DEF; i++)
            send_request(make_request(REQ_APPEND, 32'h0A00_0000 | i, 1'b0,
                                      32'hC0A8_0000 | i, 1'b0, 16'd1000 + i[15:0],
                                      16'd80, 8'd6, ~i[0]));
        send_request(make_request(REQ_APPEND, 32'h1234_5678, 1'b1, 32'h9ABC_DEF0, 1'b1,
                                  16'd0, 16'd0, 8'd0, 1'b1));
        last_pkt = make_request(REQ_CLASSIFY, 32'h0A00_000F, 1'b0, 32'hC0A8_000F, 1'b0,
                                16'd1015, 16'd80, 8'd6, 1'b1);
        send_request(last_pkt);
        last_pkt.proto_num = 8'd17;
        send_request(last_pkt);
        send_request(make_request(REQ_CLEAR, 32'h0, 1'b0, 32'h0, 1'b0,
                                  16'd0, 16'd0, 8'd0, 1'b0));
        last_pkt.proto_num = 8'd6;
        send_request(last_pkt);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        int stop_at;
        int pick;
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at) begin
            if ($urandom_range(0, 4) != 0)
                send_request(make_request(REQ_CLEAR, $urandom(), 1'($urandom_range(0, 1)),
                                          $urandom(), 1'($urandom_range(0, 1)),
                                          16'($urandom_range(0, 65535)),
                                          16'($urandom_range(0, 65535)),
                                          8'($urandom_range(0, 255)),
                                          1'($urandom_range(0, 1))));
            // now and then build past a full table
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(15, 18) : $urandom_range(1, 8))
                send_request(random_rule());
            repeat ($urandom_range(4, 20)) begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_request(make_request(REQ_RESERVED, $urandom(),
                                              1'($urandom_range(0, 1)),
                                              $urandom(), 1'($urandom_range(0, 1)),
                                              16'($urandom_range(0, 65535)),
                                              16'($urandom_range(0, 65535)),
                                              8'($urandom_range(0, 255)),
                                              1'($urandom_range(0, 1))));
                else if (pick < 12)
                    send_request(random_rule());
                else
                    send_request(random_packet());
            end
        end
        wait_drained();
    endtask

    // hold the output off long enough that the block stops taking requests
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_stall_pct <= 30;
        fork
            begin
                hold_off <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join_none
        repeat (8) send_request(random_rule());
        repeat (22) send_request(random_packet());
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_rules();
        test_table_full();
        test_random_traffic(200, 0, 0);
        test_random_traffic(180, 72, 0);
        test_random_traffic(180, 0, 72);
        test_random_traffic(160, 16, 16);
        test_output_stall();
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && awaited_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
